// ----- design/tcc_pkg.sv -----
// Shared types and widths for the triangle circumcircle pipeline.
// Used by tcc_front, tcc_div_cell, tcc_sqrt_cell and triangle_circumcircle_core.
`default_nettype none
package tcc_pkg;

    // Quotient bits produced by the divider row (one per cell)
    localparam int Q_BITS     = 33;
    // Root bits produced by the square root row (one per cell)
    localparam int ROOT_BITS  = 33;
    localparam int DEN_W      = 36;
    localparam int NUM_W      = 52;
    localparam int SQ_IN_W    = 2 * ROOT_BITS;
    localparam int SREM_W     = 35;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [Q_BITS-1:0] num_lo;
        logic [Q_BITS-1:0] quo;
        logic              neg;
        logic              ovf;
    } t_div_lane;

    typedef struct packed {
        logic               detz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
    } t_side;

    typedef struct packed {
        t_div_lane        lx;
        t_div_lane        ly;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_state;

    typedef struct packed {
        logic               detz;
        logic               csat;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
    } t_sq_side;

    typedef struct packed {
        logic [SREM_W-1:0]    rem;
        logic [ROOT_BITS-1:0] root;
        logic [SQ_IN_W-1:0]   s_rest;
        t_sq_side             side;
    } t_sq_state;

endpackage
`default_nettype wire

// ----- design/tcc_front.sv -----
// Front arithmetic: edges, squares, offsets, determinant, numerators, divider setup.
// Six registered stages; depends on tcc_pkg.
`default_nettype none
module tcc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_ax,
    input  wire logic signed [15:0] i_ay,
    input  wire logic signed [15:0] i_bx,
    input  wire logic signed [15:0] i_by,
    input  wire logic signed [15:0] i_cx,
    input  wire logic signed [15:0] i_cy,
    output logic                    o_valid,
    output tcc_pkg::t_div_state     o_state
);

    logic [5:0] r_v;

    // stage 1: edges and squares
    logic signed [16:0] r1_eax, r1_eay, r1_ebx, r1_eby;
    logic [30:0]        r1_sax, r1_say, r1_sbx, r1_sby, r1_scx, r1_scy;
    logic signed [15:0] r1_ax, r1_ay;
    logic signed [31:0] n1_sax, n1_say, n1_sbx, n1_sby, n1_scx, n1_scy;

    assign n1_sax = i_ax * i_ax;
    assign n1_say = i_ay * i_ay;
    assign n1_sbx = i_bx * i_bx;
    assign n1_sby = i_by * i_by;
    assign n1_scx = i_cx * i_cx;
    assign n1_scy = i_cy * i_cy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eax <= 17'(i_bx) - 17'(i_ax);
            r1_eay <= 17'(i_by) - 17'(i_ay);
            r1_ebx <= 17'(i_cx) - 17'(i_ax);
            r1_eby <= 17'(i_cy) - 17'(i_ay);
            r1_sax <= n1_sax[30:0];
            r1_say <= n1_say[30:0];
            r1_sbx <= n1_sbx[30:0];
            r1_sby <= n1_sby[30:0];
            r1_scx <= n1_scx[30:0];
            r1_scy <= n1_scy[30:0];
            r1_ax  <= i_ax;
            r1_ay  <= i_ay;
        end
    end

    // stage 2: squared-norm offsets, determinant products
    logic [31:0]        n2_na, n2_nb, n2_nc;
    logic signed [32:0] r2_offb, r2_offc;
    logic signed [33:0] r2_p1, r2_p2;
    logic signed [16:0] r2_eax, r2_eay, r2_ebx, r2_eby;
    logic signed [15:0] r2_ax, r2_ay;
    logic signed [33:0] n2_p1, n2_p2;

    assign n2_na = {1'b0, r1_sax} + {1'b0, r1_say};
    assign n2_nb = {1'b0, r1_sbx} + {1'b0, r1_sby};
    assign n2_nc = {1'b0, r1_scx} + {1'b0, r1_scy};
    assign n2_p1 = r1_eax * r1_eby;
    assign n2_p2 = r1_ebx * r1_eay;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_offb <= $signed({1'b0, n2_na}) - $signed({1'b0, n2_nb});
            r2_offc <= $signed({1'b0, n2_na}) - $signed({1'b0, n2_nc});
            r2_p1   <= n2_p1;
            r2_p2   <= n2_p2;
            r2_eax  <= r1_eax;
            r2_eay  <= r1_eay;
            r2_ebx  <= r1_ebx;
            r2_eby  <= r1_eby;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
        end
    end

    // stage 3: determinant, numerator products
    logic signed [34:0] r3_det;
    logic signed [49:0] r3_pxa, r3_pxb, r3_pya, r3_pyb;
    logic signed [15:0] r3_ax, r3_ay;
    logic signed [49:0] n3_pxa, n3_pxb, n3_pya, n3_pyb;
    logic signed [34:0] n3_det;

    assign n3_det = r2_p1 - r2_p2;
    assign n3_pxa = r2_eay * r2_offc;
    assign n3_pxb = r2_eby * r2_offb;
    assign n3_pya = r2_ebx * r2_offb;
    assign n3_pyb = r2_eax * r2_offc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_det <= n3_det;
            r3_pxa <= n3_pxa;
            r3_pxb <= n3_pxb;
            r3_pya <= n3_pya;
            r3_pyb <= n3_pyb;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
        end
    end

    // stage 4: numerators, determinant magnitude and zero test
    logic signed [50:0] r4_nx, r4_ny;
    logic [34:0]        r4_dmag;
    logic               r4_dneg, r4_detz;
    logic signed [15:0] r4_ax, r4_ay;
    logic signed [50:0] n4_nx, n4_ny;
    logic signed [34:0] n4_dneg_val;

    assign n4_nx       = r3_pxa - r3_pxb;
    assign n4_ny       = r3_pya - r3_pyb;
    assign n4_dneg_val = -r3_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_nx   <= n4_nx;
            r4_ny   <= n4_ny;
            r4_dneg <= r3_det[34];
            r4_dmag <= r3_det[34] ? n4_dneg_val : r3_det;
            r4_detz <= (r3_det == '0);
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
        end
    end

    // stage 5: rounded-division operands (|n| + |d|) / (2|d|)
    logic [tcc_pkg::NUM_W-1:0] r5_numx, r5_numy;
    logic [tcc_pkg::DEN_W-1:0] r5_den;
    logic                      r5_negx, r5_negy, r5_detz;
    logic signed [15:0]        r5_ax, r5_ay;
    logic signed [50:0]        n5_mx, n5_my;

    assign n5_mx = r4_nx[50] ? -r4_nx : r4_nx;
    assign n5_my = r4_ny[50] ? -r4_ny : r4_ny;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_numx <= {1'b0, n5_mx} + {17'b0, r4_dmag};
            r5_numy <= {1'b0, n5_my} + {17'b0, r4_dmag};
            r5_den  <= {r4_dmag, 1'b0};
            r5_negx <= r4_nx[50] ^ r4_dneg;
            r5_negy <= r4_ny[50] ^ r4_dneg;
            r5_detz <= r4_detz;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
        end
    end

    // stage 6: overflow precheck and divider row seed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state.lx.rem    <= {17'b0, r5_numx[51:33]};
            o_state.lx.num_lo <= r5_numx[32:0];
            o_state.lx.quo    <= '0;
            o_state.lx.neg    <= r5_negx;
            o_state.lx.ovf    <= ({17'b0, r5_numx[51:33]} >= r5_den);
            o_state.ly.rem    <= {17'b0, r5_numy[51:33]};
            o_state.ly.num_lo <= r5_numy[32:0];
            o_state.ly.quo    <= '0;
            o_state.ly.neg    <= r5_negy;
            o_state.ly.ovf    <= ({17'b0, r5_numy[51:33]} >= r5_den);
            o_state.den       <= r5_den;
            o_state.side.detz <= r5_detz;
            o_state.side.ax   <= r5_ax;
            o_state.side.ay   <= r5_ay;
        end
    end

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign o_valid = r_v[5];

endmodule
`default_nettype wire

// ----- design/tcc_div_cell.sv -----
// One cell of the divider row: one restoring quotient bit for each of the x and y lanes.
// Depends on tcc_pkg.
`default_nettype none
module tcc_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire tcc_pkg::t_div_state i_state,
    output logic                     o_valid,
    output tcc_pkg::t_div_state      o_state
);

    function automatic tcc_pkg::t_div_lane div_step(input tcc_pkg::t_div_lane l,
                                                    input logic [tcc_pkg::DEN_W-1:0] den);
        logic [tcc_pkg::DEN_W:0] cur;
        logic [tcc_pkg::DEN_W:0] diff;
        logic                    ge;
        tcc_pkg::t_div_lane      r;
        cur    = {l.rem, l.num_lo[tcc_pkg::Q_BITS-1]};
        diff   = cur - {1'b0, den};
        ge     = (cur >= {1'b0, den});
        r      = l;
        r.rem    = ge ? diff[tcc_pkg::DEN_W-1:0] : cur[tcc_pkg::DEN_W-1:0];
        r.num_lo = {l.num_lo[tcc_pkg::Q_BITS-2:0], 1'b0};
        r.quo    = {l.quo[tcc_pkg::Q_BITS-2:0], ge};
        return r;
    endfunction

    tcc_pkg::t_div_state n_state;

    // next lane values
    always_comb begin
        n_state    = i_state;
        n_state.lx = div_step(i_state.lx, i_state.den);
        n_state.ly = div_step(i_state.ly, i_state.den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule
`default_nettype wire

// ----- design/tcc_sqrt_cell.sv -----
// One cell of the square root row: one root bit per cell, two radicand bits consumed.
// Depends on tcc_pkg.
`default_nettype none
module tcc_sqrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire tcc_pkg::t_sq_state i_state,
    output logic                    o_valid,
    output tcc_pkg::t_sq_state      o_state
);

    logic [tcc_pkg::SREM_W+1:0] cur;
    logic [tcc_pkg::SREM_W+1:0] trial;
    logic [tcc_pkg::SREM_W+1:0] diff;
    logic                       ge;
    tcc_pkg::t_sq_state         n_state;

    // trial subtract of (root << 2) | 1
    always_comb begin
        cur   = {i_state.rem, i_state.s_rest[tcc_pkg::SQ_IN_W-1 -: 2]};
        trial = {2'b0, i_state.root, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
        n_state        = i_state;
        n_state.rem    = ge ? diff[tcc_pkg::SREM_W-1:0] : cur[tcc_pkg::SREM_W-1:0];
        n_state.root   = {i_state.root[tcc_pkg::ROOT_BITS-2:0], ge};
        n_state.s_rest = {i_state.s_rest[tcc_pkg::SQ_IN_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule
`default_nettype wire

// ----- design/triangle_circumcircle_core.sv -----
// Top level of the circumcircle pipeline: front, divider row, distance stages, root row.
// Depends on tcc_pkg, tcc_front, tcc_div_cell, tcc_sqrt_cell.
//
// Usage:
//   Input channel: six signed Q2.14 vertex coordinates with i_in_valid / o_in_stall.
//   Output channel: centre (signed Q18.14), radius (unsigned Q18.14) and the
//   degenerate flag with o_out_valid / i_out_stall. One result per input transfer.
//   Path from the input transfer to o_out_valid: 6 front stages, 33 divider
//   cells, 4 distance stages, 33 root cells, 1 output register. Throughput:
//   one triangle per cycle unless stalled; the whole pipe advances together.
//   Stall: while a result sits in the output register and i_out_stall is high
//   the pipe holds and o_in_stall is raised; an empty output register lets the
//   pipe keep moving, so items in flight and new transfers continue.
//   Reset: synchronous, active low; clears every valid bit, payload is left as is.
//   Collinear vertices give zero centre and radius with degenerate set; a
//   saturated centre gives radius all ones with degenerate set.
`default_nettype none
module triangle_circumcircle_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_point_a_x,
    input  wire logic signed [15:0] i_point_a_y,
    input  wire logic signed [15:0] i_point_b_x,
    input  wire logic signed [15:0] i_point_b_y,
    input  wire logic signed [15:0] i_point_c_x,
    input  wire logic signed [15:0] i_point_c_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_centre_x,
    output logic signed [31:0]      o_centre_y,
    output logic [31:0]             o_radius,
    output logic                    o_degenerate
);

    // clamp a rounded quotient to signed 32 bits; returns {sat, value}
    function automatic logic [32:0] clamp_q(input logic [tcc_pkg::Q_BITS-1:0] q,
                                            input logic neg, input logic ovf);
        logic [31:0] mag;
        logic        sat;
        mag = q[31:0];
        if (neg) begin
            sat = ovf | q[32] | (q[31] & (|q[30:0]));
            return {sat, sat ? 32'h8000_0000 : 32'(-mag)};
        end else begin
            sat = ovf | q[32] | q[31];
            return {sat, sat ? 32'h7FFF_FFFF : mag};
        end
    endfunction

    logic r_out_valid;
    logic adv;

    // whole pipe moves unless a finished result is held
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    // front stages
    logic                   v_div [0:tcc_pkg::Q_BITS];
    tcc_pkg::t_div_state    s_div [0:tcc_pkg::Q_BITS];

    tcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_ax    (i_point_a_x),
        .i_ay    (i_point_a_y),
        .i_bx    (i_point_b_x),
        .i_by    (i_point_b_y),
        .i_cx    (i_point_c_x),
        .i_cy    (i_point_c_y),
        .o_valid (v_div[0]),
        .o_state (s_div[0])
    );

    // divider row
    for (genvar k = 0; k < tcc_pkg::Q_BITS; k++) begin : g_div
        tcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_div[k]),
            .i_state (s_div[k]),
            .o_valid (v_div[k+1]),
            .o_state (s_div[k+1])
        );
    end

    // distance stage 1: clamp centre
    logic [32:0]        n_cx, n_cy;
    logic               r_e1_v;
    tcc_pkg::t_sq_side  r_e1_side;
    logic signed [15:0] r_e1_ax, r_e1_ay;

    assign n_cx = clamp_q(s_div[tcc_pkg::Q_BITS].lx.quo, s_div[tcc_pkg::Q_BITS].lx.neg,
                          s_div[tcc_pkg::Q_BITS].lx.ovf);
    assign n_cy = clamp_q(s_div[tcc_pkg::Q_BITS].ly.quo, s_div[tcc_pkg::Q_BITS].ly.neg,
                          s_div[tcc_pkg::Q_BITS].ly.ovf);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e1_side.detz <= s_div[tcc_pkg::Q_BITS].side.detz;
            r_e1_side.csat <= n_cx[32] | n_cy[32];
            r_e1_side.ox   <= n_cx[31:0];
            r_e1_side.oy   <= n_cy[31:0];
            r_e1_ax        <= s_div[tcc_pkg::Q_BITS].side.ax;
            r_e1_ay        <= s_div[tcc_pkg::Q_BITS].side.ay;
        end
    end

    // distance stage 2: |a - centre|
    logic signed [32:0] n_dx, n_dy;
    logic [31:0]        r_e2_dx, r_e2_dy;
    tcc_pkg::t_sq_side  r_e2_side;
    logic               r_e2_v;

    assign n_dx = 33'(r_e1_ax) - 33'(r_e1_side.ox);
    assign n_dy = 33'(r_e1_ay) - 33'(r_e1_side.oy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e2_dx   <= n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
            r_e2_dy   <= n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
            r_e2_side <= r_e1_side;
        end
    end

    // distance stage 3: squares
    logic [63:0]       r_e3_sx, r_e3_sy;
    tcc_pkg::t_sq_side r_e3_side;
    logic              r_e3_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e3_sx   <= r_e2_dx * r_e2_dx;
            r_e3_sy   <= r_e2_dy * r_e2_dy;
            r_e3_side <= r_e2_side;
        end
    end

    // distance stage 4: squared distance, root row seed
    logic               v_sq [0:tcc_pkg::ROOT_BITS];
    tcc_pkg::t_sq_state s_sq [0:tcc_pkg::ROOT_BITS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            s_sq[0].rem    <= '0;
            s_sq[0].root   <= '0;
            s_sq[0].s_rest <= {1'b0, {1'b0, r_e3_sx} + {1'b0, r_e3_sy}};
            s_sq[0].side   <= r_e3_side;
        end
    end

    // valid bits of the distance stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v   <= 1'b0;
            r_e2_v   <= 1'b0;
            r_e3_v   <= 1'b0;
            v_sq[0]  <= 1'b0;
        end else if (adv) begin
            r_e1_v   <= v_div[tcc_pkg::Q_BITS];
            r_e2_v   <= r_e1_v;
            r_e3_v   <= r_e2_v;
            v_sq[0]  <= r_e3_v;
        end
    end

    // root row
    for (genvar k = 0; k < tcc_pkg::ROOT_BITS; k++) begin : g_sq
        tcc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_sq[k]),
            .i_state (s_sq[k]),
            .o_valid (v_sq[k+1]),
            .o_state (s_sq[k+1])
        );
    end

    // round root to nearest, saturate, pick result
    tcc_pkg::t_sq_state          fin;
    logic                        rnd;
    logic [tcc_pkg::ROOT_BITS:0] rad;
    logic                        rsat;

    assign fin  = s_sq[tcc_pkg::ROOT_BITS];
    assign rnd  = (fin.rem > {2'b0, fin.root});
    assign rad  = {1'b0, fin.root} + {{tcc_pkg::ROOT_BITS{1'b0}}, rnd};
    assign rsat = |rad[tcc_pkg::ROOT_BITS:32];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (fin.side.detz) begin
                o_centre_x   <= '0;
                o_centre_y   <= '0;
                o_radius     <= '0;
                o_degenerate <= 1'b1;
            end else if (fin.side.csat) begin
                o_centre_x   <= fin.side.ox;
                o_centre_y   <= fin.side.oy;
                o_radius     <= 32'hFFFF_FFFF;
                o_degenerate <= 1'b1;
            end else begin
                o_centre_x   <= fin.side.ox;
                o_centre_y   <= fin.side.oy;
                o_radius     <= rsat ? 32'hFFFF_FFFF : rad[31:0];
                o_degenerate <= rsat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= v_sq[tcc_pkg::ROOT_BITS];
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // an accepted transfer enters the front stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> u_front.r_v[0])
        else $error("accepted transfer did not enter the pipe");

    // collinear item leaves as zero circle with flag
    a_collinear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && v_sq[tcc_pkg::ROOT_BITS] && fin.side.detz)
        |=> (o_out_valid && o_degenerate && o_radius == '0))
        else $error("collinear item gave a nonzero circle");

    // saturated centre forces all-ones radius
    a_csat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && v_sq[tcc_pkg::ROOT_BITS] && !fin.side.detz && fin.side.csat)
        |=> (o_degenerate && o_radius == 32'hFFFF_FFFF))
        else $error("saturated centre without flagged radius");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for triangle_circumcircle_core: directed and random triangles.
// Expected circles come from an integer circumcircle predictor in this file.
// Depends on design/tcc_pkg.sv and design/triangle_circumcircle_core.sv.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        rad;
        logic               degen;
    } t_circle;

    localparam int STALL_MAX = 19;
    localparam int IDLE_LIMIT = 2000;
    localparam int PIPE_LATENCY = 77;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [15:0] i_point_a_x = '0, i_point_a_y = '0;
    logic signed [15:0] i_point_b_x = '0, i_point_b_y = '0;
    logic signed [15:0] i_point_c_x = '0, i_point_c_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b1;
    logic signed [31:0] o_centre_x, o_centre_y;
    logic [31:0] o_radius;
    logic o_degenerate;

    t_circle expected_circles[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;

    triangle_circumcircle_core dut (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // round(n / (2d)), ties away from zero, clamped to 32 bits
    function automatic longint centre_coord(longint n, longint d, ref bit sat);
        longint unsigned an, ad, q;
        bit neg;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (an + ad) / (2 * ad);
        neg = (n < 0) != (d < 0);
        if (neg) begin
            if (q > 64'd2147483648) begin
                sat = 1'b1;
                q = 64'd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647) begin
            sat = 1'b1;
            q = 64'd2147483647;
        end
        return longint'(q);
    endfunction

    // Square root rounded to nearest
    function automatic longint unsigned root_nearest(longint unsigned s);
        longint unsigned rem, res, b;
        rem = s;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (rem > res) res += 1;
        return res;
    endfunction

    function automatic t_circle circumcircle(logic signed [15:0] p[6]);
        longint ax, ay, bx, by, cx, cy, eax, eay, ebx, eby, na, offb, offc;
        longint det, nx, ny, ox, oy, dx, dy;
        longint unsigned r;
        bit sat;
        t_circle c;
        ax = p[0]; ay = p[1]; bx = p[2]; by = p[3]; cx = p[4]; cy = p[5];
        eax = bx - ax; eay = by - ay; ebx = cx - ax; eby = cy - ay;
        na = ax * ax + ay * ay;
        offb = na - (bx * bx + by * by);
        offc = na - (cx * cx + cy * cy);
        det = eax * eby - ebx * eay;
        c = '{0, 0, 0, 1'b0};
        sat = 1'b0;
        if (det == 0) begin
            c.degen = 1'b1;
        end else begin
            nx = eay * offc - eby * offb;
            ny = ebx * offb - eax * offc;
            ox = centre_coord(nx, det, sat);
            oy = centre_coord(ny, det, sat);
            c.cx = ox[31:0];
            c.cy = oy[31:0];
            if (sat) begin
                c.degen = 1'b1;
                c.rad = '1;
            end else begin
                dx = ax - ox;
                dy = ay - oy;
                r = root_nearest(longint'(dx * dx) + longint'(dy * dy));
                if (r > 64'hFFFF_FFFF) begin
                    r = 64'hFFFF_FFFF;
                    c.degen = 1'b1;
                end
                c.rad = r[31:0];
            end
        end
        return c;
    endfunction

    // Send one triangle; predict on transfer. Valid stays high after the
    // transfer so a following item with no gap goes back to back.
    task automatic send_triangle(logic signed [15:0] p[6]);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_point_a_x <= p[0]; i_point_a_y <= p[1];
        i_point_b_x <= p[2]; i_point_b_y <= p[3];
        i_point_c_x <= p[4]; i_point_c_y <= p[5];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_circles.push_back(circumcircle(p));
        @(negedge i_clk);
    endtask

    // Receiver stall pattern: random wait per result
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            wait_n = receiver_quiet ? 0 : $urandom_range(0, STALL_MAX);
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_circle e;
            if (expected_circles.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, o_centre_x,
                         o_centre_y);
                error_count++;
            end else begin
                e = expected_circles.pop_front();
                if (o_centre_x !== e.cx) begin
                    $display("%0t: centre_x exp %0d got %0d", $time, e.cx, o_centre_x);
                    error_count++;
                end
                if (o_centre_y !== e.cy) begin
                    $display("%0t: centre_y exp %0d got %0d", $time, e.cy, o_centre_y);
                    error_count++;
                end
                if (o_radius !== e.rad) begin
                    $display("%0t: radius exp %0d got %0d", $time, e.rad, o_radius);
                    error_count++;
                end
                if (o_degenerate !== e.degen) begin
                    $display("%0t: degenerate exp %0b got %0b", $time, e.degen,
                             o_degenerate);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        return 16'($urandom);
    endfunction

    // Extremes, collinear, coincident and saturating corners
    task automatic test_directed();
        logic signed [15:0] p[6];
        p = '{16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000};
        send_triangle(p);
        p = '{-16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000};
        send_triangle(p);
        p = '{0, 0, 16384, 0, 0, 16384};
        send_triangle(p);
        p = '{0, 0, 0, 0, 0, 0};
        send_triangle(p);
        p = '{100, 100, 100, 100, 5000, -300};
        send_triangle(p);
        p = '{0, 0, 1000, 1000, -2000, -2000};
        send_triangle(p);
        p = '{-16'sh8000, -16'sh8000, 0, 0, 16'sh7FFF, 16'sh7FFF};
        send_triangle(p);
        // nearly collinear: huge centre
        p = '{-16'sh8000, 0, 16'sh7FFF, 1, 0, 0};
        send_triangle(p);
        p = '{-16'sh8000, 0, 16'sh7FFF, -1, 0, 0};
        send_triangle(p);
        p = '{0, -16'sh8000, 1, 16'sh7FFF, 0, 0};
        send_triangle(p);
        p = '{0, 0, 1, 0, 0, 1};
        send_triangle(p);
        p = '{-1, -1, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF};
        send_triangle(p);
        p = '{-16'sh5555, 16'sh2AAA, -16'sh2AAA, 16'sh5555, -1, 0};
        send_triangle(p);
    endtask

    // Random triangles with a mix of full-range, small and near-collinear shapes
    task automatic test_random(int count);
        logic signed [15:0] p[6];
        int kind, k;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            for (k = 0; k < 6; k++) p[k] = rand_coord();
            if (kind == 0) begin
                for (k = 0; k < 6; k++) p[k] = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            end else if (kind == 1) begin
                // C on line AB (approximately), maybe exactly
                p[4] = p[0] + (p[2] - p[0]) / 2 + 16'($urandom_range(0, 2)) - 16'sd1;
                p[5] = p[1] + (p[3] - p[1]) / 2 + 16'($urandom_range(0, 2)) - 16'sd1;
            end else if (kind == 2) begin
                p[2] = p[0];
                p[3] = p[1];
            end
            if (n % 400 == 200) sender_quiet = ~sender_quiet;
            if (n % 500 == 300) receiver_quiet = ~receiver_quiet;
            send_triangle(p);
        end
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // Stimulus sequence and end of run
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1600);
        i_in_valid <= 1'b0;
        wait (expected_circles.size() == 0);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
        if (error_count == 0 && expected_circles.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
design/tcc_pkg.sv
design/tcc_front.sv
design/tcc_div_cell.sv
design/tcc_sqrt_cell.sv
design/triangle_circumcircle_core.sv
sim/tb.sv
